FILE: rtl/mbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

    localparam int WEIGHT_W     = 8;
    localparam int WEIGHT_DEPTH = 128;
    localparam int POS_W        = 6;
    localparam int COEFF_W      = 12;

    localparam logic [7:0]  DC_RESET    = 8'd128;
    localparam logic [17:0] POS_LIMIT   = 18'd2047;
    localparam logic [17:0] NEG_LIMIT   = 18'd2048;

    typedef enum logic [2:0] {
        OP_LOAD_INTRA    = 3'd0,
        OP_LOAD_NONINTRA = 3'd1,
        OP_RESET_PRED    = 3'd2,
        OP_INTRA_DC      = 3'd3,
        OP_NONINTRA      = 3'd4,
        OP_AC            = 3'd5,
        OP_END           = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    function automatic logic [POS_W-1:0] zz_to_natural(input logic [POS_W-1:0] zz);
        logic [POS_W-1:0] pos;
        case (zz)
            6'd0:  pos = 6'd0;   6'd1:  pos = 6'd1;   6'd2:  pos = 6'd8;   6'd3:  pos = 6'd16;
            6'd4:  pos = 6'd9;   6'd5:  pos = 6'd2;   6'd6:  pos = 6'd3;   6'd7:  pos = 6'd10;
            6'd8:  pos = 6'd17;  6'd9:  pos = 6'd24;  6'd10: pos = 6'd32;  6'd11: pos = 6'd25;
            6'd12: pos = 6'd18;  6'd13: pos = 6'd11;  6'd14: pos = 6'd4;   6'd15: pos = 6'd5;
            6'd16: pos = 6'd12;  6'd17: pos = 6'd19;  6'd18: pos = 6'd26;  6'd19: pos = 6'd33;
            6'd20: pos = 6'd40;  6'd21: pos = 6'd48;  6'd22: pos = 6'd41;  6'd23: pos = 6'd34;
            6'd24: pos = 6'd27;  6'd25: pos = 6'd20;  6'd26: pos = 6'd13;  6'd27: pos = 6'd6;
            6'd28: pos = 6'd7;   6'd29: pos = 6'd14;  6'd30: pos = 6'd21;  6'd31: pos = 6'd28;
            6'd32: pos = 6'd35;  6'd33: pos = 6'd42;  6'd34: pos = 6'd49;  6'd35: pos = 6'd56;
            6'd36: pos = 6'd57;  6'd37: pos = 6'd50;  6'd38: pos = 6'd43;  6'd39: pos = 6'd36;
            6'd40: pos = 6'd29;  6'd41: pos = 6'd22;  6'd42: pos = 6'd15;  6'd43: pos = 6'd23;
            6'd44: pos = 6'd30;  6'd45: pos = 6'd37;  6'd46: pos = 6'd44;  6'd47: pos = 6'd51;
            6'd48: pos = 6'd58;  6'd49: pos = 6'd59;  6'd50: pos = 6'd52;  6'd51: pos = 6'd45;
            6'd52: pos = 6'd38;  6'd53: pos = 6'd31;  6'd54: pos = 6'd39;  6'd55: pos = 6'd46;
            6'd56: pos = 6'd53;  6'd57: pos = 6'd60;  6'd58: pos = 6'd61;  6'd59: pos = 6'd54;
            6'd60: pos = 6'd47;  6'd61: pos = 6'd55;  6'd62: pos = 6'd62;  default: pos = 6'd63;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mpeg1_block_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser: operation; tdata: component .. weight_index
// m_axis    out  tvalid/tready/tlast  tdata: coeff_index, coeff_value; tuser: error;
//                                     tlast: block_done
//
// Weight loads, predictor reset and non-intra start give no result and leave the block idle.
// Intra DC, end of block and an AC run past the block go straight to the emit state; AC goes through
// weight RAM read, product with the weight, then rounding and saturation into the output register.
// Both weight matrices share one 128-entry RAM with a registered read port.
// Reset (synchronous, active low) sets the predictors to 128 and the scan to 0.
// A result that is not taken holds the output register and stalls the next result.

module mpeg1_block_dequantizer
    import mbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // component[1:0], dc_size[5:2], dc_bits[13:6], run[19:14], level[27:20],
    // negative[28], quant_scale[33:29], weight[41:34], weight_index[47:42]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // coeff_index[5:0], coeff_value[17:6], zero[23:18]
    output logic [23:0]      m_axis_tdata,
    // error[0]
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int ADDR_W = $clog2(WEIGHT_DEPTH);

    t_state r_state, n_state;

    logic [6:0]         r_scan;
    logic               r_intra;
    logic [7:0]         r_pred [3];
    logic [13:0]        r_prod1;
    logic [21:0]        r_prod2;
    logic               r_neg;
    logic               r_is_ac;
    logic [POS_W-1:0]   r_res_index;
    logic [COEFF_W-1:0] r_res_value;
    logic               r_res_done;
    logic               r_res_err;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_index;
    logic [COEFF_W-1:0] r_out_value;
    logic               r_out_done;
    logic               r_out_err;

    t_op        in_op;
    logic [1:0] in_comp;
    logic [3:0] in_size;
    logic [7:0] in_bits;
    logic [5:0] in_run;
    logic [7:0] in_level;
    logic       in_neg;
    logic [4:0] in_scale;
    logic [7:0] in_weight;
    logic [5:0] in_widx;

    assign in_op     = t_op'(s_axis_tuser);
    assign in_comp   = s_axis_tdata[1:0];
    assign in_size   = s_axis_tdata[5:2];
    assign in_bits   = s_axis_tdata[13:6];
    assign in_run    = s_axis_tdata[19:14];
    assign in_level  = s_axis_tdata[27:20];
    assign in_neg    = s_axis_tdata[28];
    assign in_scale  = s_axis_tdata[33:29];
    assign in_weight = s_axis_tdata[41:34];
    assign in_widx   = s_axis_tdata[47:42];

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // scan position and zig-zag lookup
    logic [6:0]       scan_sum;
    logic             run_over;
    logic [POS_W-1:0] nat_pos;
    assign scan_sum = r_scan + {1'b0, in_run};
    assign run_over = (scan_sum > 7'd63);
    assign nat_pos  = zz_to_natural(scan_sum[POS_W-1:0]);

    // weight RAM: upper address bit selects the non-intra matrix
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;
    assign ram_we    = accept && (in_op == OP_LOAD_INTRA || in_op == OP_LOAD_NONINTRA);
    assign ram_waddr = {in_op == OP_LOAD_NONINTRA, in_widx};
    assign ram_raddr = {!r_intra, nat_pos};

    mbd_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_weight),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // DC differential and predictor update
    logic [1:0]         dc_cc;
    logic [3:0]         dc_s;
    logic [8:0]         dc_pow;
    logic [8:0]         dc_raw;
    logic signed [10:0] dc_diff;
    logic signed [10:0] dc_sum;
    logic [7:0]         dc_new;
    logic               dc_sat;

    always_comb begin
        dc_cc   = (in_comp > 2'd2) ? 2'd2 : in_comp;
        dc_s    = (in_size > 4'd8) ? 4'd8 : in_size;
        dc_pow  = 9'd1 << dc_s;
        dc_raw  = {1'b0, in_bits} & (dc_pow - 9'd1);
        if (dc_s == 4'd0) begin
            dc_diff = 11'sd0;
        end else if (dc_raw >= {1'b0, dc_pow[8:1]}) begin
            dc_diff = $signed({2'b00, dc_raw});
        end else begin
            dc_diff = $signed({2'b00, dc_raw}) + 11'sd1 - $signed({2'b00, dc_pow});
        end
        dc_sum = $signed({3'b000, r_pred[dc_cc]}) + dc_diff;
        dc_sat = 1'b0;
        dc_new = dc_sum[7:0];
        if (dc_sum < 11'sd0) begin
            dc_new = 8'd0;
            dc_sat = 1'b1;
        end else if (dc_sum > 11'sd255) begin
            dc_new = 8'd255;
            dc_sat = 1'b1;
        end
    end

    // AC rounding and saturation
    logic [17:0]        ac_mag;
    logic [17:0]        ac_odd;
    logic [COEFF_W-1:0] ac_value;

    always_comb begin
        ac_mag = r_prod2[21:4];
        ac_odd = ac_mag;
        if (ac_mag != 18'd0 && !ac_mag[0]) begin
            ac_odd = ac_mag - 18'd1;
        end
        if (r_neg) begin
            ac_value = (ac_odd > NEG_LIMIT) ? 12'h800 : COEFF_W'(-ac_odd);
        end else begin
            ac_value = (ac_odd > POS_LIMIT) ? 12'h7FF : ac_odd[COEFF_W-1:0];
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_AC && !run_over) begin
                        n_state = S_MUL;
                    end else if (in_op == OP_AC || in_op == OP_INTRA_DC || in_op == OP_END) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= 7'd0;
            r_intra     <= 1'b0;
            r_pred[0]   <= DC_RESET;
            r_pred[1]   <= DC_RESET;
            r_pred[2]   <= DC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (in_op)
                    OP_RESET_PRED: begin
                        r_pred[0] <= DC_RESET;
                        r_pred[1] <= DC_RESET;
                        r_pred[2] <= DC_RESET;
                    end
                    OP_INTRA_DC: begin
                        r_pred[dc_cc] <= dc_new;
                        r_intra       <= 1'b1;
                        r_scan        <= 7'd1;
                    end
                    OP_NONINTRA: begin
                        r_intra <= 1'b0;
                        r_scan  <= 7'd0;
                    end
                    OP_AC: begin
                        r_scan <= run_over ? 7'd64 : scan_sum + 7'd1;
                    end
                    OP_END: begin
                        r_scan <= 7'd0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod1     <= 14'({in_level, r_intra ? 1'b0 : 1'b1}) * 14'(in_scale);
            r_neg       <= in_neg;
            r_is_ac     <= (in_op == OP_AC) && !run_over;
            r_res_index <= (in_op == OP_AC && !run_over) ? nat_pos : '0;
            r_res_value <= (in_op == OP_INTRA_DC) ? {1'b0, dc_new, 3'b000} : '0;
            r_res_done  <= (in_op == OP_END);
            r_res_err   <= (in_op == OP_INTRA_DC) ? dc_sat : (in_op == OP_AC);
        end
        if (r_state == S_MUL) begin
            r_prod2 <= 22'(r_prod1) * 22'(ram_rdata);
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_index <= r_res_index;
            r_out_value <= r_is_ac ? ac_value : r_res_value;
            r_out_done  <= r_res_done;
            r_out_err   <= r_is_ac ? 1'b0 : r_res_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_value, r_out_index};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_done;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mbd_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 420;
    localparam int HOLD_CYCLES = 300;

    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    localparam logic [5:0] ZZ_NAT [0:63] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] widx;
        logic [7:0] weight;
        logic [4:0] scale;
        logic       neg;
        logic [7:0] level;
        logic [5:0] run;
        logic [7:0] dc_bits;
        logic [3:0] dc_size;
        logic [1:0] comp;
    } dq_item_t;

    typedef struct packed {
        logic [5:0]  idx;
        logic [11:0] value;
        logic        done;
        logic        err;
    } dq_res_t;

    typedef struct packed {
        logic [6:0]       scan;
        logic             intra;
        logic [2:0][7:0]  pred;
        logic [63:0][7:0] iw;
        logic [63:0][7:0] nw;
        logic [63:0]      iwr;
        logic [63:0]      nwr;
    } dq_state_t;

    typedef struct packed {
        bit      known;
        dq_res_t res;
    } dq_note_t;

    typedef struct packed {
        dq_item_t it;
        bit       known;
        dq_res_t  res;
    } dq_row_t;

    localparam dq_res_t NO_RES = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    dq_state_t pred_st;
    dq_state_t gen_st;
    dq_res_t   coeff_q [$];
    dq_note_t  note_q [$];
    dq_row_t   dir_tab [$];
    int        mismatches = 0;
    int        cycle_cnt = 0;
    int        n_sent = 0;
    int        burst_left = 0;
    int        hold_reqs = 0;

    mpeg1_block_dequantizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic dq_state_t dq_reset_state();
        dq_state_t st;
        st = '0;
        st.pred[0] = DC_RESET;
        st.pred[1] = DC_RESET;
        st.pred[2] = DC_RESET;
        return st;
    endfunction

    function automatic dq_item_t dqi(input logic [2:0] op, input int comp, input int size,
                                     input int bits, input int run, input int level,
                                     input int neg, input int scale, input int weight,
                                     input int widx);
        dq_item_t it;
        it.op      = op;
        it.comp    = comp[1:0];
        it.dc_size = size[3:0];
        it.dc_bits = bits[7:0];
        it.run     = run[5:0];
        it.level   = level[7:0];
        it.neg     = neg[0];
        it.scale   = scale[4:0];
        it.weight  = weight[7:0];
        it.widx    = widx[5:0];
        return it;
    endfunction

    function automatic dq_res_t dqr(input int idx, input int val, input int done,
                                    input int err);
        dq_res_t r;
        r.idx   = idx[5:0];
        r.value = val[11:0];
        r.done  = done[0];
        r.err   = err[0];
        return r;
    endfunction

    function automatic bit dequant_step(inout dq_state_t st, input dq_item_t it,
                                        output dq_res_t r);
        int cc, sz, half, raw, diff, sum, n, w, mult, mag, val;
        logic [5:0] pos;
        bit sat;
        r = '0;
        dequant_step = 1'b0;
        case (it.op)
            OP_LOAD_INTRA: begin
                st.iw[it.widx]  = it.weight;
                st.iwr[it.widx] = 1'b1;
            end
            OP_LOAD_NONINTRA: begin
                st.nw[it.widx]  = it.weight;
                st.nwr[it.widx] = 1'b1;
            end
            OP_RESET_PRED: begin
                st.pred[0] = DC_RESET;
                st.pred[1] = DC_RESET;
                st.pred[2] = DC_RESET;
            end
            OP_INTRA_DC: begin
                cc   = (it.comp > 2) ? 2 : it.comp;
                sz   = (it.dc_size > 8) ? 8 : it.dc_size;
                diff = 0;
                sat  = 1'b0;
                if (sz != 0) begin
                    half = 1 << (sz - 1);
                    raw  = it.dc_bits & ((1 << sz) - 1);
                    diff = (raw >= half) ? raw : raw + 1 - 2 * half;
                end
                sum = st.pred[cc] + diff;
                if (sum < 0) begin
                    sum = 0;
                    sat = 1'b1;
                end
                if (sum > 255) begin
                    sum = 255;
                    sat = 1'b1;
                end
                st.pred[cc] = sum[7:0];
                st.intra    = 1'b1;
                st.scan     = 7'd1;
                r = dqr(0, 8 * sum, 0, sat);
                dequant_step = 1'b1;
            end
            OP_NONINTRA: begin
                st.intra = 1'b0;
                st.scan  = 7'd0;
            end
            OP_AC: begin
                n = st.scan + it.run;
                if (n > 63) begin
                    st.scan = 7'd64;
                    r = dqr(0, 0, 0, 1);
                end else begin
                    pos  = ZZ_NAT[n];
                    w    = st.intra ? st.iw[pos] : st.nw[pos];
                    mult = 2 * it.level + (st.intra ? 0 : 1);
                    mag  = (mult * it.scale * w) / 16;
                    if (mag != 0 && mag[0] == 1'b0) begin
                        mag = mag - 1;
                    end
                    if (it.neg) begin
                        val = (mag > int'(NEG_LIMIT)) ? -int'(NEG_LIMIT) : -mag;
                    end else begin
                        val = (mag > int'(POS_LIMIT)) ? int'(POS_LIMIT) : mag;
                    end
                    st.scan = 7'(n + 1);
                    r = dqr(pos, val, 0, 0);
                end
                dequant_step = 1'b1;
            end
            OP_END: begin
                st.scan = 7'd0;
                r = dqr(0, 0, 1, 0);
                dequant_step = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic dq_item_t rnd_item();
        logic [63:0] rbits;
        dq_item_t it;
        rbits = {$urandom(), $urandom()};
        it = rbits[50:0];
        return it;
    endfunction

    task automatic drive_item(input dq_item_t it, input bit known, input dq_res_t res);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        note_q.push_back('{known, res});
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= it[47:0];
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.op != OP_UNUSED) begin
            n_sent++;
        end
    endtask

    // load any weight that an AC item would read before it was ever written
    task automatic issue(input dq_item_t it, input bit known, input dq_res_t res);
        dq_item_t ld;
        dq_res_t  scratch;
        int n;
        logic [5:0] pos;
        if (it.op == OP_AC) begin
            n = gen_st.scan + it.run;
            if (n <= 63) begin
                pos = ZZ_NAT[n];
                if (gen_st.intra ? !gen_st.iwr[pos] : !gen_st.nwr[pos]) begin
                    ld = rnd_item();
                    ld.op = gen_st.intra ? OP_LOAD_INTRA : OP_LOAD_NONINTRA;
                    ld.widx = pos;
                    drive_item(ld, 1'b0, NO_RES);
                    void'(dequant_step(gen_st, ld, scratch));
                end
            end
        end
        drive_item(it, known, res);
        void'(dequant_step(gen_st, it, scratch));
    endtask

    task automatic rnd_block();
        dq_item_t it;
        int n_ac;
        it = rnd_item();
        it.op = $urandom_range(0, 1) ? OP_INTRA_DC : OP_NONINTRA;
        issue(it, 1'b0, NO_RES);
        n_ac = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(0, 12);
        repeat (n_ac) begin
            it = rnd_item();
            it.op = OP_AC;
            it.run = 6'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n_ac > 12 ? 1 : 5));
            it.level = 8'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                               : $urandom_range(0, 255));
            issue(it, 1'b0, NO_RES);
        end
        if ($urandom_range(0, 7) != 0) begin
            it = rnd_item();
            it.op = OP_END;
            issue(it, 1'b0, NO_RES);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("mpeg1_block_dequantizer regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : rx_pattern
        int mode;
        int mode_left;
        int hold_cnt;
        int hold_seen;
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_cnt  = HOLD_CYCLES;
        end
        if (mode_left <= 0) begin
            mode      = $urandom_range(RX_FREE, RX_TOGGLE);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            case (mode)
                RX_FREE:   m_axis_tready <= 1'b1;
                RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
                default:   m_axis_tready <= cycle_cnt[0];
            endcase
        end
    end

    always @(posedge i_clk) begin : item_accept
        dq_item_t it;
        dq_res_t  r;
        dq_note_t note;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it = {s_axis_tuser, s_axis_tdata};
            note = note_q.pop_front();
            if (dequant_step(pred_st, it, r)) begin
                coeff_q.push_back(note.known ? note.res : r);
            end
        end
    end

    always @(posedge i_clk) begin : coeff_check
        dq_res_t got;
        dq_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = dqr(m_axis_tdata[5:0], m_axis_tdata[17:6], m_axis_tlast, m_axis_tuser[0]);
            if (coeff_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected coeff item: idx=%0d val=%0d done=%0b err=%0b",
                             got.idx, $signed(got.value), got.done, got.err);
                end
            end else begin
                want = coeff_q.pop_front();
                if (got.idx != want.idx || got.value != want.value ||
                    got.done != want.done || got.err != want.err) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("coeff mismatch: exp idx=%0d val=%0d done=%0b err=%0b,",
                                 want.idx, $signed(want.value), want.done, want.err,
                                 " got idx=%0d val=%0d done=%0b err=%0b",
                                 got.idx, $signed(got.value), got.done, got.err);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        dq_item_t it;
        bit held;
        bit paused;
        pred_st = dq_reset_state();
        gen_st  = dq_reset_state();
        held    = 1'b0;
        paused  = 1'b0;

        dir_tab.push_back('{dqi(OP_END, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b1, dqr(0, 0, 1, 0)});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 0, 0, 255, 0, 1, 0, 1, 1, 0), 1'b1,
                            dqr(0, 1024, 0, 0)});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 1, 8, 255, 0, 1, 0, 1, 1, 0), 1'b1,
                            dqr(0, 2040, 0, 1)});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 2, 8, 0, 0, 1, 0, 1, 1, 0), 1'b1,
                            dqr(0, 0, 0, 1)});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 3, 15, 128, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 0, 1, 0, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_RESET_PRED, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_INTRA_DC, 1, 0, 0, 0, 1, 0, 1, 1, 0), 1'b1,
                            dqr(0, 1024, 0, 0)});
        dir_tab.push_back('{dqi(OP_LOAD_INTRA, 0, 0, 0, 0, 1, 0, 1, 255, 1), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_LOAD_INTRA, 0, 0, 0, 0, 1, 0, 1, 1, 8), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 255, 0, 31, 0, 0), 1'b1,
                            dqr(1, 2047, 0, 0)});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 1, 1, 1, 0, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_LOAD_INTRA, 0, 0, 0, 0, 1, 0, 1, 16, 16), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 3, 1, 1, 0, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 0, 0, 31, 0, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 63, 1, 0, 1, 0, 0), 1'b1, dqr(0, 0, 0, 1)});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1, dqr(0, 0, 0, 1)});
        dir_tab.push_back('{dqi(OP_END, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b1, dqr(0, 0, 1, 0)});
        dir_tab.push_back('{dqi(OP_NONINTRA, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_LOAD_NONINTRA, 0, 0, 0, 0, 1, 0, 1, 255, 63), 1'b0,
                            NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 63, 255, 1, 31, 0, 0), 1'b1,
                            dqr(63, -2048, 0, 0)});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1, dqr(0, 0, 0, 1)});
        dir_tab.push_back('{dqi(OP_END, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b1, dqr(0, 0, 1, 0)});
        dir_tab.push_back('{dqi(OP_UNUSED, 3, 15, 255, 63, 255, 1, 31, 255, 63), 1'b0,
                            NO_RES});
        dir_tab.push_back('{dqi(OP_NONINTRA, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_AC, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0, NO_RES});
        dir_tab.push_back('{dqi(OP_END, 0, 0, 0, 0, 1, 0, 1, 1, 0), 1'b0, NO_RES});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            issue(dir_tab[k].it, dir_tab[k].known, dir_tab[k].res);
        end

        while (n_sent < ITEM_TARGET) begin
            if (!held && n_sent >= 150) begin
                held = 1'b1;
                hold_reqs++;
                burst_left = 60;
            end
            if (!paused && n_sent >= 300) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (coeff_q.size() != 0);
            end
            if ($urandom_range(0, 4) != 0) begin
                rnd_block();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    it = rnd_item();
                    issue(it, 1'b0, NO_RES);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (coeff_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && coeff_q.size() == 0) begin
            $display("mpeg1_block_dequantizer regression: pass");
        end else begin
            $display("mpeg1_block_dequantizer regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mbd_pkg.sv
rtl/mbd_ram.sv
rtl/mpeg1_block_dequantizer.sv
bench/tb.sv
